/* rtl/sbes_pkg.sv */
// ----------------------------------------------------------------------------
// sbes_pkg
// Shared types and constants of the burst estimate scheduler.
// ----------------------------------------------------------------------------
package sbes_pkg;

    localparam int SLOTS     = 16;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int SLOT_W    = 4;
    localparam int EST_W     = 16;
    localparam int COUNT_W   = 12;
    localparam int FRAC_W    = 4;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int USER_W    = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [EST_W-1:0]   IDLE_EST_RESET = {EST_W{1'b1}};

    localparam logic REG_IDLE_EST = 1'b0;

    typedef enum logic [1:0] {
        REQ_ADMIT  = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_STEP   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_SCAN,
        ST_DECIDE,
        ST_POST,
        ST_FINISH
    } state_t;

endpackage

/* rtl/sbes_ram.sv */
// ----------------------------------------------------------------------------
// sbes_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module sbes_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/srt_burst_estimate_scheduler.sv */
// ----------------------------------------------------------------------------
// srt_burst_estimate_scheduler
// Shortest-remaining-time scheduler with averaged burst estimates.
// ----------------------------------------------------------------------------
// Requests arrive as beats on the s_ channel: the request kind in s_tuser,
// the slot, the initial estimate and the blocking flag in s_tdata. Every
// request yields one result beat on the m_ channel with the active slot, a
// switch flag and the active estimate. The idle estimate is written over
// the APB port at byte address 0.
// Admit, remove and unused requests go straight to the finish state after
// acceptance. A step request scans the estimate memory one slot per cycle
// through its single read port when a slot besides idle is ready, and
// scans once more when the active process blocks. With only the idle slot
// ready a step skips the scan, also when it blocks.
// Only one request is in work at a time; the next one is accepted the cycle
// after the previous result is loaded into the output register.
// When the receiver stalls, the result waits in the output register and a
// further request is worked on but held in its final state until the
// register frees up.
// Reset makes only the idle slot ready and active, clears the run count and
// sets the idle estimate to all ones; the estimate memory needs no clearing.
// ----------------------------------------------------------------------------
module srt_burst_estimate_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // slot[3:0], initial_estimate[19:4], blocks_after[20], zero fill
    input  logic [sbes_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [sbes_pkg::USER_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // active_slot[3:0], switched[4], active_estimate[20:5], zero fill
    output logic [sbes_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbes_pkg::ADDR_W-1:0]     paddr,
    input  logic [sbes_pkg::DATA_W-1:0]     pwdata,
    output logic [sbes_pkg::DATA_W-1:0]     prdata,
    output logic                          pready
);

    import sbes_pkg::*;

    state_t               state_reg, state_next;
    logic                 pass_reg, pass_next;
    logic                 blocks_reg, blocks_next;
    logic [IDX_W-1:0]     before_reg, before_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [EST_W-1:0]     cur_est_reg, cur_est_next;
    logic [IDX_W-1:0]     best_reg, best_next;
    logic [EST_W-1:0]     best_est_reg, best_est_next;
    logic [IDX_W-1:0]     scan_addr_reg, scan_addr_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_slot_reg, cmp_slot_next;
    logic [SLOTS-1:1]     ready_reg, ready_next;
    logic [EST_W-1:0]     idle_est_reg, idle_est_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                 in_acc;
    req_t                 in_req;
    logic [SLOT_W-1:0]    in_slot;
    logic [IDX_W-1:0]     in_idx;
    logic [EST_W-1:0]     in_est;
    logic                 in_blocks;
    logic                 slot_ok;
    logic                 others;
    logic [EST_W:0]       avg_sum;
    logic [EST_W-1:0]     avg_est;
    logic [EST_W-1:0]     scan_est;
    logic [EST_W-1:0]     cur_eff_est;
    logic                 out_free;
    logic                 cfg_wr;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [EST_W-1:0]     ram_wdata;
    logic [EST_W-1:0]     ram_rdata;

    sbes_ram #(
        .WIDTH(EST_W),
        .DEPTH(SLOTS)
    ) u_est_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(scan_addr_reg),
        .rdata(ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign in_req    = req_t'(s_tuser);
    assign in_slot   = s_tdata[SLOT_W-1:0];
    assign in_idx    = IDX_W'(in_slot);
    assign in_est    = s_tdata[SLOT_W +: EST_W];
    assign in_blocks = s_tdata[SLOT_W + EST_W];
    assign slot_ok   = (in_slot != '0) && (int'(in_slot) < SLOTS);

    assign others      = |ready_reg;
    assign avg_sum     = {1'b0, cur_est_reg} + {1'b0, count_reg, {FRAC_W{1'b0}}};
    assign avg_est     = avg_sum[EST_W:1];
    assign scan_est    = (cmp_slot_reg == cur_reg) ? cur_est_reg : ram_rdata;
    assign cur_eff_est = (cur_reg == '0) ? idle_est_reg : cur_est_reg;
    assign out_free    = !out_valid_reg || m_tready;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDLE_EST) ? {{(DATA_W-EST_W){1'b0}}, idle_est_reg} : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (in_req == REQ_STEP) ? ST_SEL : ST_FINISH;
                end
            end
            ST_SEL:
            begin
                state_next = others ? ST_SCAN : ST_POST;
            end
            ST_SCAN:
            begin
                if (cmp_valid_reg && (cmp_slot_reg == IDX_W'(SLOTS - 1)))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_POST;
            end
            ST_POST:
            begin
                state_next = (!pass_reg && blocks_reg) ? ST_SEL : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pass_next       = pass_reg;
        blocks_next     = blocks_reg;
        before_next     = before_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        cur_est_next    = cur_est_reg;
        best_next       = best_reg;
        best_est_next   = best_est_reg;
        scan_addr_next  = scan_addr_reg;
        issue_done_next = issue_done_reg;
        cmp_valid_next  = 1'b0;
        cmp_slot_next   = cmp_slot_reg;
        ready_next      = ready_reg;
        idle_est_next   = cfg_wr && (paddr[2] == REG_IDLE_EST) ? pwdata[EST_W-1:0] : idle_est_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg;
        ram_wdata       = avg_est;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    before_next = cur_reg;
                    blocks_next = in_blocks;
                    pass_next   = 1'b0;
                    unique case (in_req)
                        REQ_ADMIT:
                        begin
                            if (slot_ok)
                            begin
                                ready_next[in_idx] = 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = in_idx;
                                ram_wdata = in_est;
                                if (in_idx == cur_reg)
                                begin
                                    cur_est_next = in_est;
                                end
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (slot_ok && ready_reg[in_idx])
                            begin
                                ready_next[in_idx] = 1'b0;
                                if (in_idx == cur_reg)
                                begin
                                    cur_next   = '0;
                                    count_next = '0;
                                end
                            end
                        end
                        REQ_STEP, REQ_NONE:
                        begin
                        end
                    endcase
                end
            end
            ST_SEL:
            begin
                if (!others)
                begin
                    cur_next   = '0;
                    count_next = '0;
                end
                else
                begin
                    if (cur_reg != '0)
                    begin
                        ram_we       = 1'b1;
                        cur_est_next = avg_est;
                    end
                    best_next       = '0;
                    best_est_next   = idle_est_reg;
                    scan_addr_next  = IDX_W'(1);
                    issue_done_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                cmp_valid_next = !issue_done_reg;
                cmp_slot_next  = scan_addr_reg;
                if (!issue_done_reg)
                begin
                    if (scan_addr_reg == IDX_W'(SLOTS - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + IDX_W'(1);
                    end
                end
                if (cmp_valid_reg && ready_reg[cmp_slot_reg] && (scan_est < best_est_reg))
                begin
                    best_next     = cmp_slot_reg;
                    best_est_next = scan_est;
                end
            end
            ST_DECIDE:
            begin
                if ((best_reg != cur_reg) && (best_est_reg < cur_eff_est))
                begin
                    cur_next     = best_reg;
                    count_next   = '0;
                    cur_est_next = best_est_reg;
                end
            end
            ST_POST:
            begin
                if (!pass_reg)
                begin
                    if (blocks_reg)
                    begin
                        pass_next  = 1'b1;
                        cur_next   = '0;
                        if (cur_reg != '0)
                        begin
                            count_next = '0;
                        end
                    end
                    else if ((cur_reg != '0) && (count_reg != COUNT_MAX))
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_DATA_W'({cur_eff_est, (cur_reg != before_reg),
                                                  SLOT_W'(cur_reg)});
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pass_reg       <= 1'b0;
            cur_reg        <= '0;
            count_reg      <= '0;
            issue_done_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            ready_reg      <= '0;
            idle_est_reg   <= IDLE_EST_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            cur_reg        <= cur_next;
            count_reg      <= count_next;
            issue_done_reg <= issue_done_next;
            cmp_valid_reg  <= cmp_valid_next;
            ready_reg      <= ready_next;
            idle_est_reg   <= idle_est_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blocks_reg    <= blocks_next;
        before_reg    <= before_next;
        cur_est_reg   <= cur_est_next;
        best_reg      <= best_next;
        best_est_reg  <= best_est_next;
        scan_addr_reg <= scan_addr_next;
        cmp_slot_reg  <= cmp_slot_next;
        out_data_reg  <= out_data_next;
    end

endmodule
